/* hw/rtl/bounded_circular_deque_assert.svh */
// assertion macros for the bounded circular deque
`ifndef BOUNDED_CIRCULAR_DEQUE_ASSERT_SVH
`define BOUNDED_CIRCULAR_DEQUE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define BCD_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// condition must hold in the cycle after the trigger
`define BCD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* hw/rtl/bcd_pkg.sv */
// shared types and constants for the bounded circular deque
package bcd_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned CAP_W         = 5;
  localparam int unsigned CAP_RESET     = 16;
  // result record: ok, popped, front, rear, empty, full, padded to whole bytes
  localparam int unsigned RES_W         = 3 * WORD_W + 3;
  localparam int unsigned RES_PAD_W     = ((RES_W + 7) / 8) * 8;

  localparam logic [WORD_W-1:0] NONE_WORD = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_LOOK       = 3'd4
  } kind_t;

endpackage

/* hw/rtl/bounded_circular_deque.sv */
// bounded circular deque: top level with index logic, word store and result register
//
// Double-ended queue of signed 32-bit words. Each request pushes or pops at either end,
// or only looks, and gives exactly one result: success, the popped word, the front and
// rear words and the empty and full flags. One request is taken every clock while the
// result side does not stall; a result reaches the master side through the store's
// registered read ports (one for the new front, one for the new rear) and then the
// result register. A write to the capacity register (1 to DEPTH, 0 reads as 1, larger
// values as DEPTH) empties the deque; write it only while no request is in flight.
module bounded_circular_deque #(
  parameter int unsigned DEPTH = bcd_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // capacity register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcd_pkg::CAP_W-1:0]           cfg_data,
  // request side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bcd_pkg::WORD_W-1:0]          s_tdata,   // value
  input  logic [bcd_pkg::KIND_W-1:0]          s_tuser,   // kind
  // result side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bcd_pkg::RES_PAD_W-1:0]       m_tdata    // ok, popped, front_word,
                                                          // rear_word, is_empty, is_full
);

  import bcd_pkg::*;

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned CAP_RESET_USE = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [WORD_W-1:0] mem [0:DEPTH-1];

  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cap_use;
  logic [IW-1:0] cap_last;

  logic [CMPW-1:0] cap_wr;
  logic [CMPW-1:0] cap_sel;

  logic          s_accept;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          ok_next;
  logic          pop_ok;
  logic          pop_front;

  // stage after the store read
  logic              p_valid;
  logic              p_ok;
  logic              p_pop;
  logic              p_pop_front;
  logic              p_empty;
  logic              p_full;
  logic [WORD_W-1:0] rd_front;
  logic [WORD_W-1:0] rd_rear;
  logic              byp_front;
  logic              byp_rear;
  logic [WORD_W-1:0] wd_q;
  logic              p_advance;

  // words after the last finished request
  logic [WORD_W-1:0] cur_front;
  logic [WORD_W-1:0] cur_rear;

  logic [WORD_W-1:0] front_val;
  logic [WORD_W-1:0] rear_val;
  logic [WORD_W-1:0] popped_val;

  assign cfg_ready = 1'b1;
  assign p_advance = p_valid && (!m_tvalid || m_tready);
  assign s_tready  = !p_valid || p_advance;
  assign s_accept  = s_tvalid && s_tready;

  // capacity clamp
  always_comb begin
    cap_wr = CMPW'(cfg_data);
    if (cap_wr == '0) begin
      cap_sel = CMPW'(1);
    end else if (cap_wr > CMPW'(DEPTH)) begin
      cap_sel = CMPW'(DEPTH);
    end else begin
      cap_sel = cap_wr;
    end
  end

  // index and count update
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = '0;
    ok_next    = 1'b1;
    pop_ok     = 1'b0;
    pop_front  = 1'b0;
    case (kind_t'(s_tuser))
      KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
        if (count >= cap_use) begin
          ok_next = 1'b0;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          if (count == '0) begin
            head_next = '0;
            tail_next = '0;
            wr_addr   = '0;
          end else if (kind_t'(s_tuser) == KIND_PUSH_FRONT) begin
            head_next = (head == '0) ? cap_last : head - IW'(1);
            wr_addr   = head_next;
          end else begin
            tail_next = (tail == cap_last) ? '0 : tail + IW'(1);
            wr_addr   = tail_next;
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (count == '0) begin
          ok_next = 1'b0;
        end else begin
          pop_ok     = 1'b1;
          pop_front  = (kind_t'(s_tuser) == KIND_POP_FRONT);
          count_next = count - CW'(1);
          if (count == CW'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else if (pop_front) begin
            head_next = (head == cap_last) ? '0 : head + IW'(1);
          end else begin
            tail_next = (tail == '0) ? cap_last : tail - IW'(1);
          end
        end
      end
      KIND_LOOK: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      cap_use  <= CW'(CAP_RESET_USE);
      cap_last <= IW'(CAP_RESET_USE - 1);
    end else if (cfg_valid && cfg_ready) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      cap_use  <= CW'(cap_sel);
      cap_last <= IW'(cap_sel - CMPW'(1));
    end else if (s_accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // word store with registered reads of the new front and rear
  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (wr_en) begin
        mem[wr_addr] <= s_tdata;
      end
      rd_front <= mem[head_next];
      rd_rear  <= mem[tail_next];
    end
  end

  // same-cycle write shows through on the read side
  always_ff @(posedge clk) begin
    if (s_accept) begin
      byp_front   <= wr_en && (wr_addr == head_next);
      byp_rear    <= wr_en && (wr_addr == tail_next);
      wd_q        <= s_tdata;
      p_ok        <= ok_next;
      p_pop       <= pop_ok;
      p_pop_front <= pop_front;
      p_empty     <= (count_next == '0);
      p_full      <= (count_next == cap_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_accept) begin
      p_valid <= 1'b1;
    end else if (p_advance) begin
      p_valid <= 1'b0;
    end
  end

  assign front_val  = p_empty ? NONE_WORD : (byp_front ? wd_q : rd_front);
  assign rear_val   = p_empty ? NONE_WORD : (byp_rear ? wd_q : rd_rear);
  // a popped word is the front or rear left by the request before
  assign popped_val = !p_pop ? NONE_WORD : (p_pop_front ? cur_front : cur_rear);

  always_ff @(posedge clk) begin
    if (p_advance) begin
      cur_front <= front_val;
      cur_rear  <= rear_val;
      m_tdata   <= RES_PAD_W'({p_full, p_empty, rear_val, front_val, popped_val, p_ok});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`include "bounded_circular_deque_assert.svh"

  `BCD_ASSERT_NOW(a_count_in_cap, 1'b1, count <= cap_use, "count above capacity")
  `BCD_ASSERT_NOW(a_empty_indices, count == '0, head == '0 && tail == '0, "empty deque with moved indices")
  `BCD_ASSERT_NOW(a_stall_cause, !s_tready, p_valid && m_tvalid && !m_tready, "request side stalled without cause")
  `BCD_ASSERT_NEXT(a_push_count, s_accept && wr_en && !cfg_valid, count == $past(count) + CW'(1), "push did not grow count")

endmodule

/* sim/bounded_circular_deque_checker.sv */
// result checker for the bounded circular deque: tracks the deque and compares every result
`timescale 1ns / 100ps

module bounded_circular_deque_checker #(
  parameter int unsigned DEPTH = bcd_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bcd_pkg::CAP_W-1:0]       cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [bcd_pkg::WORD_W-1:0]      s_tdata,   // value
  input  logic [bcd_pkg::KIND_W-1:0]      s_tuser,   // kind
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [bcd_pkg::RES_PAD_W-1:0]   m_tdata,   // ok, popped, front_word,
                                                     // rear_word, is_empty, is_full
  output int unsigned                     errors,
  output int unsigned                     outstanding,
  output int unsigned                     results_checked
);

  import bcd_pkg::*;

  typedef struct {
    logic              ok;
    logic [WORD_W-1:0] popped;
    logic [WORD_W-1:0] front_word;
    logic [WORD_W-1:0] rear_word;
    logic              is_empty;
    logic              is_full;
  } deque_result_t;

  deque_result_t expected_results[$];

  logic [WORD_W-1:0] word_store [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  int unsigned       held;
  logic [CAP_W-1:0]  cap_reg;

  function automatic int unsigned cap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return 32'(cap_reg);
  endfunction

  task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                               output deque_result_t res);
    int unsigned lim;
    lim        = cap_limit();
    res.ok     = 1'b1;
    res.popped = NONE_WORD;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
        if (held >= lim) begin
          res.ok = 1'b0;
        end else begin
          if (held == 0) begin
            head_idx      = 0;
            tail_idx      = 0;
            word_store[0] = value;
          end else if (kind == KIND_PUSH_FRONT) begin
            head_idx             = (head_idx == 0) ? lim - 1 : head_idx - 1;
            word_store[head_idx] = value;
          end else begin
            tail_idx             = (tail_idx + 1 >= lim) ? 0 : tail_idx + 1;
            word_store[tail_idx] = value;
          end
          held++;
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (held == 0) begin
          res.ok = 1'b0;
        end else begin
          if (kind == KIND_POP_FRONT) begin
            res.popped = word_store[head_idx];
            head_idx   = (head_idx + 1 >= lim) ? 0 : head_idx + 1;
          end else begin
            res.popped = word_store[tail_idx];
            tail_idx   = (tail_idx == 0) ? lim - 1 : tail_idx - 1;
          end
          held--;
          // last word gone: both ends go back to entry 0
          if (held == 0) begin
            head_idx = 0;
            tail_idx = 0;
          end
        end
      end
      KIND_LOOK: begin
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase
    res.front_word = (held == 0) ? NONE_WORD : word_store[head_idx];
    res.rear_word  = (held == 0) ? NONE_WORD : word_store[tail_idx];
    res.is_empty   = (held == 0);
    res.is_full    = (held == lim);
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t: result %0d: %s got %h, expected %h", $realtime, results_checked, what,
             got, want);
    errors++;
  endtask

  task automatic check_result(input logic [RES_PAD_W-1:0] data);
    deque_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, data low word", data[WORD_W-1:0], '0);
      return;
    end
    want = expected_results.pop_front();
    if (data[0] !== want.ok)
      report_mismatch("ok", WORD_W'(data[0]), WORD_W'(want.ok));
    if (data[WORD_W:1] !== want.popped)
      report_mismatch("popped", data[WORD_W:1], want.popped);
    if (data[2*WORD_W:WORD_W+1] !== want.front_word)
      report_mismatch("front_word", data[2*WORD_W:WORD_W+1], want.front_word);
    if (data[3*WORD_W:2*WORD_W+1] !== want.rear_word)
      report_mismatch("rear_word", data[3*WORD_W:2*WORD_W+1], want.rear_word);
    if (data[3*WORD_W+1] !== want.is_empty)
      report_mismatch("is_empty", WORD_W'(data[3*WORD_W+1]), WORD_W'(want.is_empty));
    if (data[3*WORD_W+2] !== want.is_full)
      report_mismatch("is_full", WORD_W'(data[3*WORD_W+2]), WORD_W'(want.is_full));
    results_checked++;
  endtask

  initial begin
    errors          = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  always @(posedge clk) begin
    deque_result_t res;
    if (rst) begin
      expected_results.delete();
      head_idx = 0;
      tail_idx = 0;
      held     = 0;
      cap_reg  = CAP_W'(CAP_RESET);
    end else begin
      // a result can never belong to a request taken in the same cycle
      if (m_tvalid && m_tready)
        check_result(m_tdata);
      if (cfg_valid && cfg_ready) begin
        cap_reg  = cfg_data;
        head_idx = 0;
        tail_idx = 0;
        held     = 0;
      end
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser, s_tdata, res);
        expected_results.push_back(res);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

/* sim/bounded_circular_deque_tb.sv */
// testbench top for the bounded circular deque: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module bounded_circular_deque_tb;

  import bcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 58;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [WORD_W-1:0]    s_tdata;   // value
  logic [KIND_W-1:0]    s_tuser;   // kind
  logic                 m_tvalid;
  logic                 m_tready;
  logic [RES_PAD_W-1:0] m_tdata;   // ok, popped, front_word, rear_word, is_empty, is_full

  int unsigned errors;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned cap_writes;
  int unsigned cycle_count;
  logic        tx_gaps_on;
  logic        rx_stalls_on;

  bounded_circular_deque i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  bounded_circular_deque_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .errors          (errors),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
    $display("TEST FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cap_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return KIND_W'($urandom_range(5, 7));
    if (r < 10) return KIND_LOOK;
    if (r < 10 + push_pct) return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
    return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR;
  endfunction

  // segments lean toward filling, draining or neither so both ends get reached
  task automatic random_phase(input logic [CAP_W-1:0] cap, input logic pause_midway);
    int unsigned push_pct;
    write_capacity(cap);
    push_pct = 50;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 15 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 45;
        endcase
      end
      if (pause_midway && i == PHASE_ITEMS / 2)
        drain_results();
      send_request(pick_kind(push_pct), pick_value());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [12];
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    requests_sent = 0;
    cap_writes    = 0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    caps = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd3, 5'd17, 5'd5, 5'd8, 5'd1, 5'd12, 5'd16, 5'd7};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty deque at reset capacity, then both ends with extreme words
    send_request(KIND_POP_FRONT, 32'h1111_1111);
    send_request(KIND_POP_REAR, 32'h2222_2222);
    send_request(KIND_LOOK, '0);
    send_request(3'd5, '1);
    send_request(KIND_PUSH_FRONT, 32'h7fff_ffff);
    send_request(KIND_PUSH_FRONT, 32'h8000_0000);
    send_request(KIND_PUSH_REAR, 32'h0000_0000);
    send_request(KIND_PUSH_REAR, 32'hffff_ffff);
    send_request(3'd6, 32'h5555_5555);
    send_request(3'd7, 32'haaaa_aaaa);
    send_request(KIND_LOOK, '0);
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_POP_REAR, '0);
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_POP_REAR, '0);
    send_request(KIND_POP_REAR, '0);

    // single entry: full after one push
    write_capacity(5'd1);
    send_request(KIND_PUSH_REAR, 32'h5a5a_5a5a);
    send_request(KIND_PUSH_FRONT, 32'ha5a5_a5a5);
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_PUSH_FRONT, 32'h1234_5678);
    send_request(KIND_POP_REAR, '0);

    for (int p = 0; p < 12; p++) begin
      if (p == 10) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end
      random_phase(caps[p], p == 4);
    end

    drain_results();
    repeat (4) @(negedge clk);

    $display("sent %0d requests across %0d capacity writes (0, 1, 16 and above 16 included)",
             requests_sent, cap_writes);
    $display("checked %0d results, %0d mismatches", results_checked, errors);
    if (errors == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
